// ===== rtl/tfh_pkg.sv =====
// Package for the Toeplitz flow hash block: payload structs, configuration
// struct, register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package tfh_pkg;

    // Widths fixed by the tuple and the key layout
    localparam int ADDR_W      = 32;
    localparam int PORT_W      = 16;
    localparam int HASH_W      = 32;
    localparam int SEED_W      = 8;
    localparam int STREAM_W    = 2 * ADDR_W + 2 * PORT_W;  // 96 hashed bits
    localparam int KEY_PERIOD  = 2 * SEED_W;               // key repeats every 16 bits
    localparam int GROUP_LEN   = STREAM_W / KEY_PERIOD;    // bits sharing one key window
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEED_EVEN     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_ODD      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INCLUDE_PORTS = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESULT_MASK   = 8'd3;

    // Reset values
    localparam logic [SEED_W-1:0] RST_SEED_EVEN     = 8'h6d;
    localparam logic [SEED_W-1:0] RST_SEED_ODD      = 8'h5a;
    localparam logic              RST_INCLUDE_PORTS = 1'b0;
    localparam logic [HASH_W-1:0] RST_RESULT_MASK   = 32'hffff_ffff;

    typedef struct packed {
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_addr;
        logic [PORT_W-1:0] src_port;
        logic [PORT_W-1:0] dst_port;
    } t_tuple;

    typedef struct packed {
        logic [HASH_W-1:0] hash_value;
        logic [HASH_W-1:0] masked_hash;
    } t_hash_result;

    typedef struct packed {
        logic [SEED_W-1:0] seed_even;
        logic [SEED_W-1:0] seed_odd;
        logic              include_ports;
        logic [HASH_W-1:0] result_mask;
    } t_cfg;

endpackage

// ===== rtl/tfh_cfg_regs.sv =====
// Configuration register file for the Toeplitz flow hash block.
// Depends on tfh_pkg for register indexes, reset values and t_cfg.
`timescale 1ns / 1ps

module tfh_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tfh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tfh_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output tfh_pkg::t_cfg                 o_cfg
);

    tfh_pkg::t_cfg r_cfg;
    tfh_pkg::t_cfg n_cfg;

    // Always take a write transaction
    assign o_cfg_ready = 1'b1;

    // Decode the write; drop indexes beyond the register list
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                tfh_pkg::REG_SEED_EVEN:     n_cfg.seed_even     = i_cfg_data[tfh_pkg::SEED_W-1:0];
                tfh_pkg::REG_SEED_ODD:      n_cfg.seed_odd      = i_cfg_data[tfh_pkg::SEED_W-1:0];
                tfh_pkg::REG_INCLUDE_PORTS: n_cfg.include_ports = i_cfg_data[0];
                tfh_pkg::REG_RESULT_MASK:   n_cfg.result_mask   = i_cfg_data[tfh_pkg::HASH_W-1:0];
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seed_even     <= tfh_pkg::RST_SEED_EVEN;
            r_cfg.seed_odd      <= tfh_pkg::RST_SEED_ODD;
            r_cfg.include_ports <= tfh_pkg::RST_INCLUDE_PORTS;
            r_cfg.result_mask   <= tfh_pkg::RST_RESULT_MASK;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/tfh_hash_core.sv =====
// Combinational Toeplitz hash of one IPv4 tuple with a two-byte periodic key.
// Depends on tfh_pkg for t_tuple, t_cfg and t_hash_result.
`timescale 1ns / 1ps

module tfh_hash_core (
    input  tfh_pkg::t_tuple      i_tuple,
    input  tfh_pkg::t_cfg        i_cfg,
    output tfh_pkg::t_hash_result o_result
);

    localparam int SW = tfh_pkg::STREAM_W;
    localparam int KP = tfh_pkg::KEY_PERIOD;
    localparam int GL = tfh_pkg::GROUP_LEN;
    localparam int HW = tfh_pkg::HASH_W;
    localparam int KW = 3 * KP;   // key span wide enough for any window

    logic [SW-1:0]           stream;
    logic [KW-1:0]           key_span;
    logic [KP-1:0]           parity;
    logic [KP-1:0][HW-1:0]   window;
    logic [HW-1:0]           hash;

    // Build the bit stream in wire order; zero the ports when they are off
    assign stream = {i_tuple.src_addr, i_tuple.dst_addr,
                     i_cfg.include_ports ? i_tuple.src_port : {tfh_pkg::PORT_W{1'b0}},
                     i_cfg.include_ports ? i_tuple.dst_port : {tfh_pkg::PORT_W{1'b0}}};

    assign key_span = {3{i_cfg.seed_even, i_cfg.seed_odd}};

    // Fold stream bits that share a key window (same position modulo the key period)
    always_comb begin
        logic [GL-1:0] group;
        for (int k = 0; k < KP; k++) begin
            for (int m = 0; m < GL; m++) begin
                group[m] = stream[SW-1-k-KP*m];
            end
            parity[k] = ^group;
            window[k] = key_span[KW-1-k -: HW];
        end
    end

    // Each hash bit is the parity of the windows whose folded bit is set
    always_comb begin
        logic [KP-1:0] terms;
        for (int j = 0; j < HW; j++) begin
            for (int k = 0; k < KP; k++) begin
                terms[k] = parity[k] & window[k][j];
            end
            hash[j] = ^terms;
        end
    end

    assign o_result.hash_value  = hash;
    assign o_result.masked_hash = hash & i_cfg.result_mask;

endmodule

// ===== rtl/toeplitz_flow_hash_top.sv =====
// Top level of the Toeplitz flow hash block: input register, hash core,
// result register and configuration registers. Depends on tfh_pkg,
// tfh_cfg_regs and tfh_hash_core.
`timescale 1ns / 1ps

// Computes the 32-bit Toeplitz receive-side hash of an IPv4 flow tuple
// (source and destination address, optionally source and destination port)
// under a periodic key that alternates seed_even and seed_odd, and returns
// it with a masked copy. One tuple is taken every cycle while the output is
// not stalled. A result is offered once the result register holds it: the
// tuple sits in the input register while the hash logic works on it, and
// the result register takes the hash when it has room. The input register
// refills whenever it is empty or its tuple moves on, so full throughput
// holds while the downstream side keeps ready high. A stalled output holds
// at most two transactions before input ready drops, and input ready
// follows output ready combinationally. Configuration writes are taken in
// every cycle and should be issued only while no tuple is in flight.
module toeplitz_flow_hash_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  tfh_pkg::t_tuple                i_tuple,
    output logic                           o_valid,
    input  logic                           i_ready,
    output tfh_pkg::t_hash_result          o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tfh_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tfh_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    tfh_pkg::t_cfg         cfg;
    tfh_pkg::t_hash_result core_result;

    logic                  r_in_valid;
    tfh_pkg::t_tuple       r_in_tuple;
    logic                  r_out_valid;
    tfh_pkg::t_hash_result r_out_result;
    logic                  out_advance;
    logic                  in_advance;

    tfh_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tfh_hash_core u_hash_core (
        .i_tuple  (r_in_tuple),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    // Result stage frees up when empty or when its transaction is taken
    assign out_advance = !r_out_valid || i_ready;
    // Input stage frees up when empty or when it can move into the result stage
    assign in_advance  = !r_in_valid || out_advance;
    assign o_ready     = in_advance;

    // Hold the accepted tuple
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_advance) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_advance && i_valid) begin
            r_in_tuple <= i_tuple;
        end
    end

    // Capture the hash into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_advance && r_in_valid) begin
            r_out_result <= core_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out_result;

endmodule
